@@ rtl/core/gtwl_pkg.sv @@
// Shared types, constants and helpers for the greedy word-wrap layout block.
// No dependencies.
package gtwl_pkg;

  localparam int unsigned MaxWord = 32;
  localparam int unsigned WordIdxW = $clog2(MaxWord);
  localparam int unsigned WordCntW = $clog2(MaxWord + 1);
  localparam int unsigned GeomW = 48;
  localparam int unsigned OrigW = 24;

  localparam logic [2:0] CfgTextScale = 3'd0;
  localparam logic [2:0] CfgLetterSpacing = 3'd1;
  localparam logic [2:0] CfgLineHeight = 3'd2;
  localparam logic [2:0] CfgLineIndent = 3'd3;
  localparam logic [2:0] CfgWrapWidth = 3'd4;
  localparam logic [2:0] CfgDirectionUp = 3'd5;
  localparam logic [2:0] CfgStartY = 3'd6;

  localparam logic signed [25:0] S24Min = -26'sd8388608;
  localparam logic signed [25:0] S24Max = 26'sd8388607;

  localparam logic [20:0] CpNewline = 21'h0000A;
  localparam logic [20:0] CpUnderscore = 21'h0005F;

  typedef struct packed {
    logic [15:0] text_scale;
    logic signed [15:0] letter_spacing;
    logic signed [23:0] line_height;
    logic signed [23:0] line_indent;
    logic [22:0] wrap_width;
    logic direction_up;
    logic signed [23:0] start_y;
  } cfg_t;

  function automatic logic is_cjk(input logic [20:0] c);
    is_cjk = (c == 21'h3005) || (c >= 21'h3400 && c <= 21'h4DBF) ||
             (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'hF900 && c <= 21'hFAFF) ||
             (c >= 21'h20000 && c <= 21'h2A6DF) || (c >= 21'h2A700 && c <= 21'h2B73F) ||
             (c >= 21'h2B740 && c <= 21'h2B81F) || (c >= 21'h2F800 && c <= 21'h2FA1F);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
    if (v < 41'(S24Min)) sat24 = 24'sh800000;
    else if (v > 41'(S24Max)) sat24 = 24'sh7FFFFF;
    else sat24 = v[23:0];
  endfunction

  function automatic logic [22:0] satu23(input logic signed [40:0] v);
    if (v < 0) satu23 = '0;
    else if (v > 41'sd8388607) satu23 = 23'h7FFFFF;
    else satu23 = v[22:0];
  endfunction

endpackage

@@ rtl/core/greedy_text_word_wrap_layout.sv @@
// Top level of the greedy word-wrap text layout block.
// Depends on gtwl_pkg, gtwl_cfg and gtwl_ram.
//
// Input channel: one glyph per transaction (code point, alpha flag, metrics,
// final flag) on in_valid/in_stall. Output channel: one placed glyph box per
// transaction on out_valid/out_stall, with last_of_run on the last box of an
// input and end_of_text plus text sizes on the box of the final glyph.
// A glyph that does not close a word is written to the word buffer. A closing
// word of several glyphs is read back from the two word buffer RAMs one glyph
// at a time: read, scale multiply, place into the output register. A word of
// one glyph, and every glyph without wrapping, skips the read. The block
// accepts no glyph until the current word or glyph has been placed; a stalled
// output holds its box and the emit sequence waits.
// Reset clears pen state, control and the output valid flag; buffer contents
// are left undefined and are always written before being read.
module greedy_text_word_wrap_layout (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [20:0]        code_point_i,
  input  logic               is_alpha_i,
  input  logic [11:0]        advance_i,
  input  logic [11:0]        box_height_i,
  input  logic [11:0]        bitmap_width_i,
  input  logic [11:0]        bitmap_height_i,
  input  logic signed [11:0] origin_x_i,
  input  logic signed [11:0] origin_y_i,
  input  logic               final_glyph_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] glyph_x_o,
  output logic signed [23:0] glyph_y_o,
  output logic [22:0]        glyph_w_o,
  output logic [22:0]        glyph_h_o,
  output logic signed [23:0] text_width_o,
  output logic [22:0]        text_height_o,
  output logic               last_of_run_o,
  output logic               end_of_text_o
);
  import gtwl_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StMul = 3'd2;
  localparam logic [2:0] StPut = 3'd3;

  cfg_t cfg;
  gtwl_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we, .cfg_index, .cfg_wdata, .cfg_o(cfg)
  );

  logic [2:0] st_q, st_d;
  logic signed [23:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [22:0] font_h_q, font_h_d;
  logic [22:0] word_sum_q, word_sum_d;
  logic [WordCntW-1:0] cnt_q, cnt_d;
  logic [WordCntW-1:0] idx_q, idx_d;
  logic started_q, started_d, wrap_q, wrap_d, closed_q, closed_d;
  logic fin_q, fin_d, nl_after_q, nl_after_d, space_q, space_d;
  logic single_q, single_d;
  logic [GeomW-1:0] g_q, g_d;
  logic [OrigW-1:0] o_q, o_d;
  logic [15:0] s_q;
  logic [27:0] w_p_q, h_p_q, bw_p_q, bh_p_q;
  logic signed [28:0] bx_p_q, by_p_q;
  logic lst_q, lst_d;

  logic ov_q, ov_d;
  logic signed [23:0] ox_q, ox_d, oy_q, oy_d, tw_q, tw_d;
  logic [22:0] ow_q, ow_d, oh_q, oh_d, th_q, th_d;
  logic olast_q, olast_d, oend_q, oend_d;

  logic ram_we;
  logic [WordIdxW-1:0] ram_wa, ram_ra;
  logic [GeomW-1:0] geom_rd, geom_wr;
  logic [OrigW-1:0] orig_rd, orig_wr;

  gtwl_ram #(.Width(GeomW), .Depth(MaxWord)) u_geom (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(geom_wr),
    .raddr_i(ram_ra), .rdata_o(geom_rd)
  );
  gtwl_ram #(.Width(OrigW), .Depth(MaxWord)) u_orig (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(orig_wr),
    .raddr_i(ram_ra), .rdata_o(orig_rd)
  );

  logic in_acc, out_free;
  assign out_free = !ov_q || !out_stall;
  assign in_stall = (st_q != StIdle);
  assign in_acc = in_valid && !in_stall;
  assign geom_wr = {bitmap_height_i, bitmap_width_i, box_height_i, advance_i};
  assign orig_wr = {origin_y_i, origin_x_i};
  assign ram_ra = idx_d[WordIdxW-1:0];

  // Scale products of the item latched in g_q/o_q.
  always_ff @(posedge clk_i) begin
    if (st_q == StMul) begin
      w_p_q <= g_q[11:0] * s_q;
      h_p_q <= g_q[23:12] * s_q;
      bw_p_q <= g_q[35:24] * s_q;
      bh_p_q <= g_q[47:36] * s_q;
      bx_p_q <= $signed(o_q[11:0]) * $signed({1'b0, s_q});
      by_p_q <= $signed(o_q[23:12]) * $signed({1'b0, s_q});
    end
  end

  always_comb begin
    logic signed [23:0] px, py, adv_sel;
    logic signed [40:0] t;
    logic [22:0] hs, fh;
    logic [27:0] hp, ap;
    logic [WordCntW-1:0] k;
    logic wm, closes, brk, cl;
    st_d = st_q; pen_x_d = pen_x_q; pen_y_d = pen_y_q; font_h_d = font_h_q;
    word_sum_d = word_sum_q; cnt_d = cnt_q; idx_d = idx_q; started_d = started_q;
    wrap_d = wrap_q; closed_d = closed_q; fin_d = fin_q; nl_after_d = nl_after_q;
    space_d = space_q; single_d = single_q; g_d = g_q; o_d = o_q; lst_d = lst_q;
    ov_d = ov_q && out_stall; ox_d = ox_q; oy_d = oy_q; ow_d = ow_q; oh_d = oh_q;
    tw_d = tw_q; th_d = th_q; olast_d = olast_q; oend_d = oend_q;
    ram_we = 1'b0; ram_wa = '0;
    px = pen_x_q; py = pen_y_q; fh = font_h_q; k = cnt_q; wm = wrap_q; cl = closed_q;
    hp = box_height_i * cfg.text_scale;
    ap = advance_i * cfg.text_scale;
    hs = satu23(41'($signed({1'b0, hp})));
    adv_sel = '0; t = '0; closes = 1'b0; brk = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          fin_d = final_glyph_i;
          if (!started_q) begin
            wm = (cfg.wrap_width != '0);
            wrap_d = wm;
            started_d = 1'b1;
            px = wm ? 24'sd0 : sat24(-41'(cfg.letter_spacing));
            py = cfg.start_y;
            fh = wm ? hs : '0;
            word_sum_d = '0; k = '0; closed_d = 1'b0; cl = 1'b0;
          end
          pen_y_d = py;
          if (!wm) begin
            px = sat24(41'(px) + 41'(cfg.letter_spacing));
            if (hs > fh) fh = hs;
            g_d = geom_wr; o_d = orig_wr; lst_d = 1'b1;
            nl_after_d = 1'b0; space_d = 1'b0; single_d = 1'b0; cnt_d = '0; idx_d = '0;
            st_d = StMul;
          end else begin
            if (k >= WordCntW'(MaxWord)) k = WordCntW'(MaxWord - 1);
            ram_we = 1'b1; ram_wa = k[WordIdxW-1:0];
            k = k + 1'b1;
            t = 41'($signed({1'b0, word_sum_q})) + 41'($signed({1'b0, ap}));
            word_sum_d = satu23(t);
            brk = (code_point_i != CpUnderscore) && !is_alpha_i;
            closes = final_glyph_i || is_cjk(code_point_i) || brk ||
                     (k >= WordCntW'(MaxWord));
            cnt_d = k;
            if (closes) begin
              adv_sel = (cfg.line_height != 0) ? cfg.line_height : 24'(fh);
              idx_d = '0;
              if (k == 1) begin
                space_d = 1'b0;
                single_d = 1'b1;
                nl_after_d = (code_point_i == CpNewline);
                g_d = geom_wr; o_d = orig_wr; lst_d = 1'b1;
                st_d = StMul;
              end else begin
                space_d = cl;
                single_d = 1'b0;
                nl_after_d = 1'b0;
                if (41'(px) + 41'($signed({1'b0, word_sum_d})) >
                    41'($signed({1'b0, cfg.wrap_width})) ||
                    code_point_i == CpNewline) begin
                  pen_y_d = sat24(cfg.direction_up ? 41'(py) - 41'(adv_sel)
                                                   : 41'(py) + 41'(adv_sel));
                  px = cfg.line_indent;
                end
                st_d = StRead;
              end
              closed_d = 1'b1;
            end
          end
          pen_x_d = px; font_h_d = fh;
        end
      end
      StRead: begin
        g_d = geom_rd; o_d = orig_rd;
        lst_d = (idx_q + 1'b1 == cnt_q);
        st_d = StMul;
      end
      StMul: st_d = StPut;
      StPut: begin
        if (out_free) begin
          px = pen_x_q;
          if (space_q) px = sat24(41'(px) + 41'(cfg.letter_spacing));
          ov_d = 1'b1;
          ox_d = sat24(41'(px) + 41'(bx_p_q));
          oy_d = sat24(41'(pen_y_q) + 41'($signed({1'b0, h_p_q})) - 41'(by_p_q) -
                       41'($signed({1'b0, bh_p_q})));
          ow_d = satu23(41'($signed({1'b0, bw_p_q})));
          oh_d = satu23(41'($signed({1'b0, bh_p_q})));
          px = sat24(41'(px) + 41'($signed({1'b0, w_p_q})));
          py = pen_y_q;
          olast_d = lst_q; oend_d = 1'b0; tw_d = '0; th_d = '0;
          if (lst_q) begin
            if (wrap_q && (nl_after_q || (single_q &&
                41'(px) > 41'($signed({1'b0, cfg.wrap_width}))))) begin
              adv_sel = (cfg.line_height != 0) ? cfg.line_height : 24'(font_h_q);
              py = sat24(cfg.direction_up ? 41'(py) - 41'(adv_sel)
                                          : 41'(py) + 41'(adv_sel));
              px = cfg.line_indent;
            end
            if (fin_q) begin
              oend_d = 1'b1;
              tw_d = px;
              th_d = satu23((py < 0 ? -41'(py) : 41'(py)) +
                            41'($signed({1'b0, font_h_q})));
              started_d = 1'b0;
            end
            cnt_d = '0; word_sum_d = '0;
            st_d = StIdle;
          end else begin
            idx_d = idx_q + 1'b1;
            st_d = StRead;
          end
          pen_x_d = px; pen_y_d = py;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pen_x_q <= '0; pen_y_q <= '0; font_h_q <= '0;
      word_sum_q <= '0; cnt_q <= '0; idx_q <= '0; started_q <= 1'b0;
      wrap_q <= 1'b0; closed_q <= 1'b0; fin_q <= 1'b0; nl_after_q <= 1'b0;
      space_q <= 1'b0; single_q <= 1'b0; lst_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; pen_x_q <= pen_x_d; pen_y_q <= pen_y_d; font_h_q <= font_h_d;
      word_sum_q <= word_sum_d; cnt_q <= cnt_d; idx_q <= idx_d;
      started_q <= started_d; wrap_q <= wrap_d; closed_q <= closed_d;
      fin_q <= fin_d; space_q <= space_d; single_q <= single_d;
      lst_q <= lst_d; ov_q <= ov_d;
      nl_after_q <= nl_after_d;
    end
  end

  always_ff @(posedge clk_i) begin
    g_q <= g_d; o_q <= o_d; s_q <= cfg.text_scale;
    ox_q <= ox_d; oy_q <= oy_d; ow_q <= ow_d; oh_q <= oh_d;
    tw_q <= tw_d; th_q <= th_d; olast_q <= olast_d; oend_q <= oend_d;
  end

  assign out_valid = ov_q;
  assign glyph_x_o = ox_q;
  assign glyph_y_o = oy_q;
  assign glyph_w_o = ow_q;
  assign glyph_h_o = oh_q;
  assign text_width_o = tw_q;
  assign text_height_o = th_q;
  assign last_of_run_o = olast_q;
  assign end_of_text_o = oend_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && end_of_text_o |-> last_of_run_o) else $error("end without last");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> in_stall) else $error("accept while busy");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= WordCntW'(MaxWord)) else $error("word count overflow");
endmodule

@@ rtl/core/gtwl_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module gtwl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/core/gtwl_cfg.sv @@
// Configuration register file of the layout block.
// Depends on gtwl_pkg.
module gtwl_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_wdata,
  output gtwl_pkg::cfg_t      cfg_o
);
  import gtwl_pkg::*;
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      cfg_q.text_scale <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgTextScale: cfg_q.text_scale <= cfg_wdata[15:0];
        CfgLetterSpacing: cfg_q.letter_spacing <= cfg_wdata[15:0];
        CfgLineHeight: cfg_q.line_height <= cfg_wdata;
        CfgLineIndent: cfg_q.line_indent <= cfg_wdata;
        CfgWrapWidth: cfg_q.wrap_width <= cfg_wdata[22:0];
        CfgDirectionUp: cfg_q.direction_up <= cfg_wdata[0];
        CfgStartY: cfg_q.start_y <= cfg_wdata;
        default: ;
      endcase
    end
  end
  assign cfg_o = cfg_q;
endmodule

@@ test/tb_top.sv @@
// Testbench for greedy_text_word_wrap_layout: random and directed glyph streams,
// results predicted by a scoreboard class and compared box by box.
// Depends on gtwl_pkg and the layout RTL.
module tb_top;
  import gtwl_pkg::*;

  typedef struct {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [22:0] w;
    logic [22:0] h;
    logic signed [23:0] tw;
    logic [22:0] th;
    logic lr;
    logic eot;
  } glyph_box_t;

  typedef struct {
    logic [20:0] cp;
    logic alpha;
    logic [11:0] adv;
    logic [11:0] bh;
    logic [11:0] bmw;
    logic [11:0] bmh;
    logic signed [11:0] ox;
    logic signed [11:0] oy;
    logic fin;
  } glyph_in_t;

  class layout_scoreboard;
    glyph_box_t pending[$];
    int errors;
    longint scale, spacing, lheight, indent, wwidth, dirup, sy;
    longint px, py, fh, wsum;
    int wcount;
    bit started, wrapping, closed;
    glyph_in_t wbuf[MaxWord];

    function new();
      scale = 256; spacing = 0; lheight = 0; indent = 0; wwidth = 0; dirup = 0; sy = 0;
      px = 0; py = 0; fh = 0; wsum = 0; wcount = 0; started = 0; wrapping = 0; closed = 0;
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        CfgTextScale: scale = d[15:0];
        CfgLetterSpacing: spacing = $signed(d[15:0]);
        CfgLineHeight: lheight = $signed(d);
        CfgLineIndent: indent = $signed(d);
        CfgWrapWidth: wwidth = d[22:0];
        CfgDirectionUp: dirup = d[0];
        CfgStartY: sy = $signed(d);
        default: ;
      endcase
    endfunction

    function void place(glyph_in_t g);
      glyph_box_t b;
      longint bh, bmh;
      bh = longint'(g.bh) * scale;
      bmh = longint'(g.bmh) * scale;
      b.x = 24'(clamp(px + longint'(g.ox) * scale, -8388608, 8388607));
      b.y = 24'(clamp(py + bh - longint'(g.oy) * scale - bmh, -8388608, 8388607));
      b.w = 23'(clamp(longint'(g.bmw) * scale, 0, 8388607));
      b.h = 23'(clamp(bmh, 0, 8388607));
      b.tw = '0; b.th = '0; b.lr = 1'b0; b.eot = 1'b0;
      pending = {pending, b};
      px = clamp(px + longint'(g.adv) * scale, -8388608, 8388607);
    endfunction

    function void break_line();
      longint a;
      a = lheight != 0 ? lheight : fh;
      if (dirup) a = -a;
      py = clamp(py + a, -8388608, 8388607);
      px = indent;
    endfunction

    function void note_input(glyph_in_t g);
      longint hs, ay;
      int n, k;
      bit lb;
      n = 0;
      hs = clamp(longint'(g.bh) * scale, 0, 8388607);
      if (!started) begin
        started = 1;
        wrapping = wwidth != 0;
        px = wrapping ? 0 : -spacing;
        py = sy;
        fh = wrapping ? hs : 0;
        wsum = 0; wcount = 0; closed = 0;
      end
      if (!wrapping) begin
        px = clamp(px + spacing, -8388608, 8388607);
        if (hs > fh) fh = hs;
        place(g);
        n = 1;
      end else begin
        k = wcount < int'(MaxWord) ? wcount : int'(MaxWord) - 1;
        lb = g.cp == CpNewline;
        wbuf[k] = g;
        wcount = k + 1;
        wsum = clamp(wsum + longint'(g.adv) * scale, 0, 8388607);
        if (g.fin || is_cjk(g.cp) || (g.cp != CpUnderscore && !g.alpha) ||
            wcount >= int'(MaxWord))
        begin
          if (wcount == 1) begin
            place(wbuf[0]);
            n = 1;
            if (px > wwidth || lb) break_line();
          end else begin
            if (px + wsum > wwidth || lb) break_line();
            for (int i = 0; i < wcount; i++) begin
              if (closed) px = clamp(px + spacing, -8388608, 8388607);
              place(wbuf[i]);
            end
            n = wcount;
          end
          closed = 1; wcount = 0; wsum = 0;
        end
      end
      if (n > 0) begin
        pending[$].lr = 1'b1;
        if (g.fin) begin
          ay = py < 0 ? -py : py;
          pending[$].tw = 24'(px);
          pending[$].th = 23'(clamp(ay + fh, 0, 8388607));
          pending[$].eot = 1'b1;
        end
      end
      if (g.fin) started = 0;
    endfunction

    function void check_result(glyph_box_t a);
      glyph_box_t e;
      if (pending.size() == 0) begin
        $error("unexpected glyph box x=%0d y=%0d", a.x, a.y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin $error("glyph_x exp %0d got %0d", e.x, a.x); errors++; end
      if (a.y !== e.y) begin $error("glyph_y exp %0d got %0d", e.y, a.y); errors++; end
      if (a.w !== e.w) begin $error("glyph_w exp %0d got %0d", e.w, a.w); errors++; end
      if (a.h !== e.h) begin $error("glyph_h exp %0d got %0d", e.h, a.h); errors++; end
      if (a.tw !== e.tw) begin $error("text_width exp %0d got %0d", e.tw, a.tw); errors++; end
      if (a.th !== e.th) begin $error("text_height exp %0d got %0d", e.th, a.th); errors++; end
      if (a.lr !== e.lr) begin $error("last_of_run exp %0d got %0d", e.lr, a.lr); errors++; end
      if (a.eot !== e.eot) begin
        $error("end_of_text exp %0d got %0d", e.eot, a.eot); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [20:0] code_point_i = '0;
  logic is_alpha_i = 0;
  logic [11:0] advance_i = '0, box_height_i = '0, bitmap_width_i = '0, bitmap_height_i = '0;
  logic signed [11:0] origin_x_i = '0, origin_y_i = '0;
  logic final_glyph_i = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [23:0] glyph_x_o, glyph_y_o, text_width_o;
  logic [22:0] glyph_w_o, glyph_h_o, text_height_o;
  logic last_of_run_o, end_of_text_o;

  layout_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  longint cycles = 0;

  always #5 clk_i = ~clk_i;

  greedy_text_word_wrap_layout u_dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_result('{glyph_x_o, glyph_y_o, glyph_w_o, glyph_h_o, text_width_o,
                        text_height_o, last_of_run_o, end_of_text_o});
  end

  // receiver stall: random bursts, one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (400) @(posedge clk_i);
        out_stall <= 0;
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1;
        repeat (n) @(posedge clk_i);
        out_stall <= 0;
      end
      @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_glyph(glyph_in_t g);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1;
    code_point_i <= g.cp; is_alpha_i <= g.alpha; advance_i <= g.adv;
    box_height_i <= g.bh; bitmap_width_i <= g.bmw; bitmap_height_i <= g.bmh;
    origin_x_i <= g.ox; origin_y_i <= g.oy; final_glyph_i <= g.fin;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_input(g);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic glyph_in_t rand_glyph(bit fin);
    glyph_in_t g;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin g.cp = 21'($urandom_range(97, 122)); g.alpha = 1'b1; end
    else if (r == 6) begin g.cp = 21'h20; g.alpha = 1'b0; end
    else if (r == 7) begin g.cp = CpNewline; g.alpha = 1'b0; end
    else if (r == 8) begin
      g.cp = 21'($urandom_range(21'h4E00, 21'h9FFF)); g.alpha = 1'b1;
    end
    else begin g.cp = 21'($urandom); g.alpha = 1'($urandom); end
    if ($urandom_range(0, 15) == 0) g.cp = CpUnderscore;
    if ($urandom_range(0, 7) == 0) begin
      g.adv = 12'($urandom); g.bh = 12'($urandom); g.bmw = 12'($urandom);
      g.bmh = 12'($urandom); g.ox = 12'($urandom); g.oy = 12'($urandom);
    end else begin
      g.adv = 12'($urandom_range(4, 20)); g.bh = 12'($urandom_range(8, 24));
      g.bmw = 12'($urandom_range(0, 20)); g.bmh = 12'($urandom_range(0, 24));
      g.ox = 12'(int'($urandom_range(0, 6)) - 3); g.oy = 12'($urandom_range(0, 20));
    end
    g.fin = fin;
    return g;
  endfunction

  initial begin
    glyph_in_t g;
    int sent;
    logic [23:0] setting[7];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, CJK, underscore, newline, full buffer
    write_reg(CfgWrapWidth, 24'd5000);
    g = '{21'h1FFFFF, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'sh800, 12'sd2047, 1'b0};
    send_glyph(g);
    g = '{CpUnderscore, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'sd2047, 12'sh800, 1'b0};
    send_glyph(g);
    g = '{21'h3005, 1'b0, 12'd10, 12'd10, 12'd10, 12'd10, 12'sd0, 12'sd0, 1'b0};
    send_glyph(g);
    g = '{CpNewline, 1'b0, 12'd5, 12'd5, 12'd5, 12'd5, 12'sd1, 12'sd1, 1'b0};
    send_glyph(g);
    for (int i = 0; i < 34; i++) begin
      g = '{21'h61, 1'b1, 12'd3, 12'd9, 12'd2, 12'd2, 12'sd0, 12'sd0, i == 33};
      send_glyph(g);
    end
    drain();

    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) setting = '{24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      else if (phase == 1)
        setting = '{24'hFFFF, 24'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd1, 24'h7FFFFF};
      else if (phase == 2)
        setting = '{24'd0, 24'h8000, 24'h800000, 24'h800000, 24'd1, 24'd0, 24'h800000};
      else begin
        setting[0] = 24'($urandom_range(64, 512));
        setting[1] = 24'(int'($urandom_range(0, 512)) - 256);
        setting[2] = $urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(0, 9000));
        setting[3] = 24'($urandom_range(0, 2000));
        setting[4] = $urandom_range(0, 3) == 0 ? 24'd0 : 24'($urandom_range(2000, 40000));
        setting[5] = 24'($urandom);
        setting[6] = 24'(int'($urandom_range(0, 100000)) - 50000);
      end
      for (int r = 0; r < 7; r++) write_reg(r[2:0], setting[r]);
      if (phase == 6) calm = 1;
      for (int i = 0; i < 55; i++) begin
        if (phase == 4 && i == 10) hold_off = 1;
        send_glyph(rand_glyph($urandom_range(0, 11) == 0 || i == 54));
        sent++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/gtwl_pkg.sv
rtl/core/gtwl_ram.sv
rtl/core/gtwl_cfg.sv
rtl/core/greedy_text_word_wrap_layout.sv
test/tb_top.sv
